### rtl/scaled_clipped_sprite_blit_core_macros.svh
// Assertion shorthands for the sprite blit core checkers.
`ifndef SCALED_CLIPPED_SPRITE_BLIT_CORE_MACROS_SVH
`define SCALED_CLIPPED_SPRITE_BLIT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scsb check failed");

// Next-cycle implication, disabled during reset.
`define SCSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scsb check failed");

`endif

### rtl/scsb_pkg.sv
package scsb_pkg;

    localparam int STORE_PIXELS = 65536;
    localparam int STORE_AW     = $clog2(STORE_PIXELS);
    localparam int PIXEL_BITS   = 32;

    localparam int DIM_W      = 13;
    localparam int COORD_W    = 16;
    localparam int CLIP_W     = 18;
    localparam int POS_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int FRAME_W    = 8;
    localparam int KIND_W     = 2;
    localparam int PIX_PORT_W = 32;
    localparam int LOAD_IDX_W = 16;
    localparam int DIV_NUM_W  = DIM_W + FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int LOAD_IDX_LSB = 0;
    localparam int PIXEL_IN_LSB = LOAD_IDX_LSB + LOAD_IDX_W;
    localparam int PLACE_X_LSB  = PIXEL_IN_LSB + PIX_PORT_W;
    localparam int PLACE_Y_LSB  = PLACE_X_LSB + COORD_W;
    localparam int FRAME_LSB    = PLACE_Y_LSB + COORD_W;
    localparam int IN_TDATA_W   = FRAME_LSB + FRAME_W;
    localparam int OUT_TDATA_W  = 2 * COORD_W + PIX_PORT_W;

    localparam logic [DIM_W-1:0]   RST_SRC_W   = DIM_W'(16);
    localparam logic [DIM_W-1:0]   RST_SRC_H   = DIM_W'(16);
    localparam logic [DIM_W-1:0]   RST_SCL_W   = DIM_W'(16);
    localparam logic [DIM_W-1:0]   RST_SCL_H   = DIM_W'(16);
    localparam logic [COORD_W-1:0] RST_CLIP_L  = COORD_W'(0);
    localparam logic [COORD_W-1:0] RST_CLIP_T  = COORD_W'(0);
    localparam logic [COORD_W-1:0] RST_CLIP_R  = COORD_W'(32767);
    localparam logic [COORD_W-1:0] RST_CLIP_B  = COORD_W'(32767);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_STEP  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_W  = 3'd0,
        REG_SRC_H  = 3'd1,
        REG_SCL_W  = 3'd2,
        REG_SCL_H  = 3'd3,
        REG_CLIP_L = 3'd4,
        REG_CLIP_T = 3'd5,
        REG_CLIP_R = 3'd6,
        REG_CLIP_B = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_DIVH_GO,
        ST_DIVH_WAIT,
        ST_DIVV_GO,
        ST_DIVV_WAIT,
        ST_INIT,
        ST_ROW,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic mem_wr;
        logic latch_start;
        logic clip;
        logic div_start;
        logic div_vert;
        logic latch_step_h;
        logic latch_step_v;
        logic init_pos;
        logic row;
        logic read;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic div_busy;
        logic out_free;
        logic fin;
    } t_stat;

endpackage

### rtl/scaled_clipped_sprite_blit_core.sv
// Load item: written to the sprite store in its accept cycle, ready again next cycle.
// Step item: after accept, the row address multiply (ST_ROW), the store read (ST_READ) and the
//   output load (ST_EMIT, held while the output register is full); then the next item is taken.
// Start item: clip, then the bit-serial divider run once per axis, then position init;
//   an empty clip result returns to idle without running the divider.
// Reset (i_rst_n low, synchronous): idle, no blit active, registers at defaults; store kept.
module scaled_clipped_sprite_blit_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // load_index[15:0], pixel_in[47:16], place_x[63:48], place_y[79:64], frame[87:80]
    input  logic [scsb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  logic [scsb_pkg::KIND_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // write_x[15:0], write_y[31:16], pixel_out[63:32]
    output logic [scsb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // write_valid[0]
    output logic [0:0]                        m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scsb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scsb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import scsb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    scsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    scsb_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

    assign m_axis_tuser = 1'b1;
    assign o_cfg_ready  = 1'b1;

endmodule

### rtl/scsb_div.sv
module scsb_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [scsb_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [scsb_pkg::DIM_W-1:0]      i_den,
    output logic                            o_busy,
    output logic [scsb_pkg::DIV_NUM_W-1:0]  o_quo
);
    import scsb_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIM_W-1:0]     r_rem;
    logic [DIM_W-1:0]     r_den;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_NUM_W-1:0] r_quo;

    logic [DIM_W:0]   shifted;
    logic             ge;
    logic [DIM_W-1:0] n_rem;

    assign shifted = {r_rem, r_num[DIV_NUM_W-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign n_rem   = ge ? DIM_W'(shifted - {1'b0, r_den}) : DIM_W'(shifted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_NUM_W - 1);
            r_rem <= '0;
            r_den <= i_den;
            r_num <= i_num;
            r_quo <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= n_rem;
            r_num <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

### rtl/scsb_ctrl.sv
module scsb_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic [scsb_pkg::KIND_W-1:0]  i_s_tuser,
    output logic                         o_s_tready,
    input  scsb_pkg::t_stat              i_stat,
    output scsb_pkg::t_cmd               o_cmd
);
    import scsb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_active;
    logic   n_active;
    logic   accept;
    t_kind  kind;

    assign kind   = t_kind'(i_s_tuser);
    assign accept = i_s_tvalid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (kind)
                        KIND_START: if (!r_active) n_state = ST_CLIP;
                        KIND_STEP:  if (r_active) n_state = ST_ROW;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLIP:      n_state = ST_DIVH_GO;
            ST_DIVH_GO:   n_state = i_stat.empty ? ST_IDLE : ST_DIVH_WAIT;
            ST_DIVH_WAIT: if (!i_stat.div_busy) n_state = ST_DIVV_GO;
            ST_DIVV_GO:   n_state = ST_DIVV_WAIT;
            ST_DIVV_WAIT: if (!i_stat.div_busy) n_state = ST_INIT;
            ST_INIT:      n_state = ST_IDLE;
            ST_ROW:       n_state = ST_READ;
            ST_READ:      n_state = ST_EMIT;
            ST_EMIT:      if (i_stat.out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        n_active   = r_active;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready       = 1'b1;
                o_cmd.mem_wr     = accept && (kind == KIND_LOAD);
                o_cmd.latch_start = accept && (kind == KIND_START) && !r_active;
            end
            ST_CLIP: o_cmd.clip = 1'b1;
            ST_DIVH_GO: begin
                o_cmd.div_start = !i_stat.empty;
            end
            ST_DIVH_WAIT: o_cmd.latch_step_h = !i_stat.div_busy;
            ST_DIVV_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_vert  = 1'b1;
            end
            ST_DIVV_WAIT: o_cmd.latch_step_v = !i_stat.div_busy;
            ST_INIT: begin
                o_cmd.init_pos = 1'b1;
                n_active       = 1'b1;
            end
            ST_ROW:  o_cmd.row  = 1'b1;
            ST_READ: o_cmd.read = 1'b1;
            ST_EMIT: begin
                o_cmd.emit = i_stat.out_free;
                if (i_stat.out_free && i_stat.fin) begin
                    n_active = 1'b0;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
        end
    end

endmodule

### rtl/scsb_dpath.sv
module scsb_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  scsb_pkg::t_cmd                    i_cmd,
    output scsb_pkg::t_stat                   o_stat,
    input  logic [scsb_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                              i_cfg_valid,
    input  logic [scsb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scsb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [scsb_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                              o_m_tlast
);
    import scsb_pkg::*;

    // configuration
    logic [DIM_W-1:0]          r_src_w, r_src_h, r_scl_w, r_scl_h;
    logic signed [COORD_W-1:0] r_clip_l, r_clip_t, r_clip_r, r_clip_b;

    // start operands
    logic signed [COORD_W-1:0] r_px, r_py;
    logic [FRAME_W-1:0]        r_frame;

    // blit setup
    logic                 r_empty;
    logic [COORD_W-1:0]   r_origin_x, r_origin_y;
    logic [DIM_W-1:0]     r_span_cols, r_span_rows;
    logic [DIM_W-1:0]     r_dx, r_dy;
    logic [STORE_AW-1:0]  r_frame_row;
    logic [POS_W-1:0]     r_step_h, r_step_v;

    // walk state
    logic [POS_W-1:0]     r_row_start, r_col_pos, r_row_pos;
    logic [DIM_W-1:0]     r_col_cnt, r_row_cnt;
    logic [STORE_AW-1:0]  r_row_addr;

    // sprite store
    logic [PIXEL_BITS-1:0] r_mem [STORE_PIXELS];
    logic [PIXEL_BITS-1:0] r_rd;

    // output register
    logic                  r_out_valid;
    logic [COORD_W-1:0]    r_out_x, r_out_y;
    logic [PIX_PORT_W-1:0] r_out_pix;
    logic                  r_out_last;

    logic signed [CLIP_W-1:0] px_e, py_e, cl_e, ct_e, cr_e, cb_e, dw_e, dh_e;
    logic signed [CLIP_W-1:0] x1, y1, x2a, y2a, x2, y2;
    logic                     empty_c;
    logic [STORE_AW-1:0]      frame_row_c, row_addr_c, rd_addr_c, wr_addr_c;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIM_W-1:0]         div_den;
    logic                     div_busy;
    logic [DIV_NUM_W-1:0]     div_quo;
    logic [DIM_W:0]           n_col, n_row;
    logic                     col_wrap, row_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= RST_SRC_W;
            r_src_h  <= RST_SRC_H;
            r_scl_w  <= RST_SCL_W;
            r_scl_h  <= RST_SCL_H;
            r_clip_l <= signed'(RST_CLIP_L);
            r_clip_t <= signed'(RST_CLIP_T);
            r_clip_r <= signed'(RST_CLIP_R);
            r_clip_b <= signed'(RST_CLIP_B);
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SRC_W:  r_src_w  <= i_cfg_data[DIM_W-1:0];
                REG_SRC_H:  r_src_h  <= i_cfg_data[DIM_W-1:0];
                REG_SCL_W:  r_scl_w  <= i_cfg_data[DIM_W-1:0];
                REG_SCL_H:  r_scl_h  <= i_cfg_data[DIM_W-1:0];
                REG_CLIP_L: r_clip_l <= signed'(i_cfg_data);
                REG_CLIP_T: r_clip_t <= signed'(i_cfg_data);
                REG_CLIP_R: r_clip_r <= signed'(i_cfg_data);
                REG_CLIP_B: r_clip_b <= signed'(i_cfg_data);
                default:    r_src_w  <= r_src_w;
            endcase
        end
    end

    // clip the scaled rectangle
    assign px_e = CLIP_W'(r_px);
    assign py_e = CLIP_W'(r_py);
    assign cl_e = CLIP_W'(r_clip_l);
    assign ct_e = CLIP_W'(r_clip_t);
    assign cr_e = CLIP_W'(r_clip_r);
    assign cb_e = CLIP_W'(r_clip_b);
    assign dw_e = signed'(CLIP_W'(r_scl_w));
    assign dh_e = signed'(CLIP_W'(r_scl_h));

    assign x1  = (px_e > cl_e) ? px_e : cl_e;
    assign y1  = (py_e > ct_e) ? py_e : ct_e;
    assign x2a = px_e + dw_e;
    assign y2a = py_e + dh_e;
    assign x2  = (x2a > cr_e) ? cr_e : x2a;
    assign y2  = (y2a > cb_e) ? cb_e : y2a;
    assign empty_c = (r_scl_w == '0) || (r_scl_h == '0) || (x1 >= x2) || (y1 >= y2);

    assign frame_row_c = STORE_AW'(r_frame) * STORE_AW'(r_src_h);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_start) begin
            r_px    <= signed'(i_s_tdata[PLACE_X_LSB +: COORD_W]);
            r_py    <= signed'(i_s_tdata[PLACE_Y_LSB +: COORD_W]);
            r_frame <= i_s_tdata[FRAME_LSB +: FRAME_W];
        end
        if (i_cmd.clip) begin
            r_empty     <= empty_c;
            r_origin_x  <= COORD_W'(x1);
            r_origin_y  <= COORD_W'(y1);
            r_span_cols <= DIM_W'(x2 - x1);
            r_span_rows <= DIM_W'(y2 - y1);
            r_dx        <= DIM_W'(x1 - px_e);
            r_dy        <= DIM_W'(y1 - py_e);
        end
    end

    // track the live source height
    always_ff @(posedge i_clk) begin
        r_frame_row <= frame_row_c;
    end

    // step sizes
    assign div_num = i_cmd.div_vert ? {r_src_h, FRAC_W'(0)} : {r_src_w, FRAC_W'(0)};
    assign div_den = i_cmd.div_vert ? r_scl_h : r_scl_w;

    scsb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_step_h) begin
            r_step_h <= POS_W'(div_quo);
        end
        if (i_cmd.latch_step_v) begin
            r_step_v <= POS_W'(div_quo);
        end
    end

    // walk
    assign n_col    = {1'b0, r_col_cnt} + 1'b1;
    assign n_row    = {1'b0, r_row_cnt} + 1'b1;
    assign col_wrap = n_col >= {1'b0, r_span_cols};
    assign row_wrap = n_row >= {1'b0, r_span_rows};

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_pos) begin
            r_row_start <= r_step_h * POS_W'(r_dx);
            r_col_pos   <= r_step_h * POS_W'(r_dx);
            r_row_pos   <= r_step_v * POS_W'(r_dy);
            r_col_cnt   <= '0;
            r_row_cnt   <= '0;
        end else if (i_cmd.emit) begin
            if (col_wrap) begin
                r_col_cnt <= '0;
                r_col_pos <= r_row_start;
                r_row_cnt <= DIM_W'(n_row);
                r_row_pos <= r_row_pos + r_step_v;
            end else begin
                r_col_cnt <= DIM_W'(n_col);
                r_col_pos <= r_col_pos + r_step_h;
            end
        end
    end

    // sample address
    assign row_addr_c = (r_frame_row + STORE_AW'(r_row_pos[POS_W-1:FRAC_W]))
                        * STORE_AW'(r_src_w);
    assign rd_addr_c  = r_row_addr + STORE_AW'(r_col_pos[POS_W-1:FRAC_W]);
    assign wr_addr_c  = STORE_AW'(i_s_tdata[LOAD_IDX_LSB +: LOAD_IDX_W]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.row) begin
            r_row_addr <= row_addr_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[wr_addr_c] <= i_s_tdata[PIXEL_IN_LSB +: PIXEL_BITS];
        end
        if (i_cmd.read) begin
            r_rd <= r_mem[rd_addr_c];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_x    <= r_origin_x + COORD_W'(r_col_cnt);
            r_out_y    <= r_origin_y + COORD_W'(r_row_cnt);
            r_out_pix  <= PIX_PORT_W'(r_rd);
            r_out_last <= col_wrap && row_wrap;
        end
    end

    assign o_stat.empty    = r_empty;
    assign o_stat.div_busy = div_busy;
    assign o_stat.out_free = !r_out_valid || i_m_tready;
    assign o_stat.fin      = col_wrap && row_wrap;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_pix, r_out_y, r_out_x};
    assign o_m_tlast  = r_out_last;

endmodule

### rtl/scsb_checker.sv
`include "scaled_clipped_sprite_blit_core_macros.svh"

module scsb_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [scsb_pkg::KIND_W-1:0]       s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [scsb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [0:0]                        m_axis_tuser,
    input logic                              m_axis_tlast
);
    import scsb_pkg::*;

    // hold a stalled result
    `SCSB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // every result is a pixel write
    `SCSB_ASSERT_NOW(a_write_flag, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser[0])

    // a new result only comes out of a busy input side
    `SCSB_ASSERT_NOW(a_emit_busy, i_clk, i_rst_n, $rose(m_axis_tvalid), !$past(s_axis_tready))

    // a load transaction leaves the input side ready
    `SCSB_ASSERT_NEXT(a_load_ready, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_LOAD), s_axis_tready)

endmodule

bind scaled_clipped_sprite_blit_core scsb_checker u_scsb_checker (.*);
